// ----- rtl/core/tsr_pkg.sv -----
package tsr_pkg;

	localparam int unsigned STAMP_BITS   = 48;
	localparam int unsigned SAMPLE_BITS  = 16;
	localparam int unsigned PERIOD_BITS  = 20;
	localparam int unsigned FRAC_BITS    = 16;
	localparam int unsigned FIFO_DEPTH   = 2048;
	localparam int unsigned FIFO_AW      = $clog2(FIFO_DEPTH);
	localparam int unsigned FILL_W       = $clog2(FIFO_DEPTH + 1);
	localparam int unsigned ENTRY_W      = STAMP_BITS + SAMPLE_BITS;
	localparam int unsigned PROD_W       = FRAC_BITS + SAMPLE_BITS + 3;
	localparam int unsigned DIV_CNT_W    = $clog2(FRAC_BITS);
	localparam int unsigned PERIOD_RESET = 22;

	localparam int unsigned CFG_IDX_W  = 1;
	localparam int unsigned CFG_DATA_W = STAMP_BITS;
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_START  = CFG_IDX_W'(1);

	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
	localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	typedef logic [STAMP_BITS-1:0]         stamp_t;
	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic [PERIOD_BITS-1:0]        period_t;

	typedef enum logic {
		CMD_PUSH = 1'b0,
		CMD_TICK = 1'b1
	} cmd_t;

	typedef enum logic {
		KIND_PUSH   = 1'b0,
		KIND_SAMPLE = 1'b1
	} kind_t;

	typedef struct packed {
		cmd_t    cmd;
		stamp_t  stamp;
		sample_t value;
	} cmd_item_t;

	typedef struct packed {
		kind_t   kind;
		sample_t value;
		logic    dropped;
	} res_item_t;

	typedef struct packed {
		period_t period;
		stamp_t  start;
	} cfg_t;

	typedef struct packed {
		logic [FILL_W-1:0] fill;
		logic              idle;
	} eng_status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_CMP,
		ST_CHECK,
		ST_DIV,
		ST_MUL,
		ST_SUM,
		ST_EMIT
	} eng_state_t;

	function automatic logic [QUEUE_AW-1:0] qptr_inc(input logic [QUEUE_AW-1:0] p);
		return (p == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : p + QUEUE_AW'(1);
	endfunction

	function automatic logic [FIFO_AW-1:0] fptr_inc(input logic [FIFO_AW-1:0] p);
		return (p == FIFO_AW'(FIFO_DEPTH - 1)) ? '0 : p + FIFO_AW'(1);
	endfunction

endpackage

// ----- rtl/core/tsr_cmd_queue.sv -----
module tsr_cmd_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  tsr_pkg::cmd_item_t  wr_item,
	output logic                full,
	output logic                rd_valid,
	input  logic                rd_en,
	output tsr_pkg::cmd_item_t  rd_item
);
	import tsr_pkg::*;

	cmd_item_t               slot_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]     wr_ptr_q;
	logic [QUEUE_AW-1:0]     rd_ptr_q;
	logic [QUEUE_CNT_W-1:0]  count_q;
	logic                    do_wr;
	logic                    do_rd;

	assign full     = (count_q == QUEUE_CNT_W'(QUEUE_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_item  = slot_q[rd_ptr_q];
	assign do_wr    = wr_en && !full;
	assign do_rd    = rd_en && rd_valid;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= qptr_inc(wr_ptr_q);
			end
			if (do_rd) begin
				rd_ptr_q <= qptr_inc(rd_ptr_q);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + QUEUE_CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - QUEUE_CNT_W'(1);
			end
		end
	end

endmodule

// ----- rtl/core/tsr_result_queue.sv -----
module tsr_result_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  tsr_pkg::res_item_t  wr_item,
	output logic                wr_ready,
	output logic                empty,
	input  logic                pop,
	output tsr_pkg::res_item_t  rd_item
);
	import tsr_pkg::*;

	res_item_t               slot_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]     wr_ptr_q;
	logic [QUEUE_AW-1:0]     rd_ptr_q;
	logic [QUEUE_CNT_W-1:0]  count_q;
	logic                    do_wr;
	logic                    do_rd;

	assign wr_ready = (count_q != QUEUE_CNT_W'(QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign rd_item  = slot_q[rd_ptr_q];
	assign do_wr    = wr_en && wr_ready;
	assign do_rd    = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			slot_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= qptr_inc(wr_ptr_q);
			end
			if (do_rd) begin
				rd_ptr_q <= qptr_inc(rd_ptr_q);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + QUEUE_CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - QUEUE_CNT_W'(1);
			end
		end
	end

endmodule

// ----- rtl/core/tsr_engine.sv -----
module tsr_engine (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tsr_pkg::cfg_t         cfg,
	input  logic                  cmd_valid,
	input  tsr_pkg::cmd_item_t    cmd_item,
	output logic                  cmd_pop,
	output logic                  res_valid,
	output tsr_pkg::res_item_t    res_item,
	input  logic                  res_ready,
	output tsr_pkg::eng_status_t  status
);
	import tsr_pkg::*;

	eng_state_t state_q;
	eng_state_t state_d;

	// sample store and its pointers
	logic [ENTRY_W-1:0]  mem [FIFO_DEPTH];
	logic [ENTRY_W-1:0]  rd_data_q;
	logic [FIFO_AW-1:0]  head_q;
	logic [FIFO_AW-1:0]  tail_q;
	logic [FILL_W-1:0]   fill_q;
	logic                mem_wr;
	logic                mem_rd;

	stamp_t  prev_stamp_q;
	sample_t prev_level_q;
	stamp_t  next_stamp_q;
	sample_t next_level_q;
	stamp_t  play_q;
	logic    started_q;

	stamp_t                    rem_q;
	stamp_t                    den_q;
	logic [FRAC_BITS:0]        frac_q;
	logic [DIV_CNT_W-1:0]      div_cnt_q;
	logic signed [PROD_W-1:0]  prod_q;
	res_item_t                 res_q;

	logic                        fifo_full;
	stamp_t                      head_stamp;
	sample_t                     head_level;
	logic                        head_due;
	logic                        span_ok;
	logic                        past_prev;
	stamp_t                      span;
	stamp_t                      play_dist;
	logic [STAMP_BITS:0]         two_rem;
	logic [STAMP_BITS:0]         rem_sub;
	logic                        sub_ok;
	logic signed [SAMPLE_BITS:0] diff;
	logic signed [FRAC_BITS+1:0] frac_s;
	logic signed [PROD_W-1:0]    prod_d;
	logic                        is_push;

	assign fifo_full  = (fill_q == FILL_W'(FIFO_DEPTH));
	assign head_stamp = rd_data_q[ENTRY_W-1:SAMPLE_BITS];
	assign head_level = rd_data_q[SAMPLE_BITS-1:0];
	assign head_due   = (head_stamp <= play_q);
	assign span_ok    = (next_stamp_q > prev_stamp_q);
	assign past_prev  = (play_q > prev_stamp_q);
	assign span       = next_stamp_q - prev_stamp_q;
	assign play_dist  = play_q - prev_stamp_q;
	assign two_rem    = {rem_q, 1'b0};
	assign sub_ok     = (two_rem >= {1'b0, den_q});
	assign rem_sub    = two_rem - {1'b0, den_q};
	assign diff       = {next_level_q[SAMPLE_BITS-1], next_level_q}
	                  - {prev_level_q[SAMPLE_BITS-1], prev_level_q};
	assign frac_s     = {1'b0, frac_q};
	assign prod_d     = PROD_W'(frac_s) * PROD_W'(diff);
	assign is_push    = (cmd_item.cmd == CMD_PUSH);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					if (is_push) begin
						state_d = ST_EMIT;
					end else if (fill_q != '0) begin
						state_d = ST_READ;
					end else begin
						state_d = ST_CHECK;
					end
				end
			end
			ST_READ: state_d = ST_CMP;
			ST_CMP: begin
				if (head_due && fill_q != FILL_W'(1)) begin
					state_d = ST_READ;
				end else begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (span_ok && past_prev && play_dist < span) begin
					state_d = ST_DIV;
				end else begin
					state_d = ST_MUL;
				end
			end
			ST_DIV: begin
				if (div_cnt_q == DIV_CNT_W'(FRAC_BITS - 1)) begin
					state_d = ST_MUL;
				end
			end
			ST_MUL: state_d = ST_SUM;
			ST_SUM: state_d = ST_EMIT;
			ST_EMIT: begin
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd_pop     = (state_q == ST_IDLE) && cmd_valid;
		mem_wr      = (state_q == ST_IDLE) && cmd_valid && is_push && !fifo_full;
		mem_rd      = (state_q == ST_READ);
		res_valid   = (state_q == ST_EMIT);
		status.idle = (state_q == ST_IDLE);
		status.fill = fill_q;
	end

	assign res_item = res_q;

	always_ff @(posedge clk) begin
		if (mem_wr) begin
			mem[tail_q] <= {cmd_item.stamp, cmd_item.value};
		end
		if (mem_rd) begin
			rd_data_q <= mem[head_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			head_q       <= '0;
			tail_q       <= '0;
			fill_q       <= '0;
			prev_stamp_q <= '0;
			prev_level_q <= '0;
			next_stamp_q <= '0;
			next_level_q <= '0;
			play_q       <= '0;
			started_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					if (mem_wr) begin
						tail_q <= fptr_inc(tail_q);
						fill_q <= fill_q + FILL_W'(1);
					end
					if (cmd_valid && !is_push && !started_q) begin
						play_q    <= cfg.start;
						started_q <= 1'b1;
					end
				end
				ST_CMP: begin
					if (head_due) begin
						prev_stamp_q <= head_stamp;
						prev_level_q <= head_level;
						head_q       <= fptr_inc(head_q);
						fill_q       <= fill_q - FILL_W'(1);
					end else begin
						next_stamp_q <= head_stamp;
						next_level_q <= head_level;
					end
				end
				ST_SUM: begin
					play_q <= play_q + STAMP_BITS'(cfg.period);
				end
				default: begin
				end
			endcase
		end
	end

	// fraction, product and result payload
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				res_q.kind    <= KIND_PUSH;
				res_q.value   <= '0;
				res_q.dropped <= fifo_full;
			end
			ST_CHECK: begin
				rem_q     <= play_dist;
				den_q     <= span;
				div_cnt_q <= '0;
				// full step once the play clock reaches the next stamp
				if (span_ok && past_prev && play_dist >= span) begin
					frac_q <= {1'b1, {FRAC_BITS{1'b0}}};
				end else begin
					frac_q <= '0;
				end
			end
			ST_DIV: begin
				rem_q     <= sub_ok ? rem_sub[STAMP_BITS-1:0] : two_rem[STAMP_BITS-1:0];
				frac_q    <= {frac_q[FRAC_BITS-1:0], sub_ok};
				div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
			end
			ST_MUL: begin
				prod_q <= prod_d;
			end
			ST_SUM: begin
				// arithmetic shift floors; the sum stays between the two levels
				res_q.kind    <= KIND_SAMPLE;
				res_q.value   <= prev_level_q + prod_q[FRAC_BITS +: SAMPLE_BITS];
				res_q.dropped <= 1'b0;
			end
			default: begin
			end
		endcase
	end

endmodule

// ----- rtl/core/timestamped_sample_resampler_core.sv -----
// Timestamped sample resampler: linear interpolation of a timestamped sample
// stream onto a fixed output grid.
// Input channel (push/full): cmd 0 stores (stamp_us, in_value) in a 2048-entry
// sample store, cmd 1 is an output tick. An item transfers on a rising edge
// with push high and full low; a two-entry command queue lets the sender run
// ahead while the engine works.
// Result channel (empty/pop): one result per input item, in order. A push
// answers kind 0 with dropped set when the store was full; a tick answers
// kind 1 with the interpolated out_value. Pop with empty low takes it; a
// two-entry result queue holds results while the receiver stalls, and the
// engine halts in its emit step once that queue is full.
// Sequencing: a push passes through the idle and emit steps only; a tick reads
// and compares each store entry examined (each popped entry, plus the peeked
// one), then checks, multiplies, sums and emits, adding the fraction divide
// when the play clock lies strictly inside the span. The store's single read
// port and the one-bit-per-cycle divider set the length of this sequence.
// Configuration (cfg_write/cfg_index/cfg_data): register 0 is period_us,
// register 1 is start_time_us; write only while the block is idle.
// Reset clears the queues, store pointers, sample registers and play clock;
// period_us returns to 22 and start_time_us to 0.
module timestamped_sample_resampler_core (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   push,
	output logic                                   full,
	input  logic                                   cmd,
	input  logic [tsr_pkg::STAMP_BITS-1:0]         stamp_us,
	input  logic signed [tsr_pkg::SAMPLE_BITS-1:0] in_value,
	output logic                                   empty,
	input  logic                                   pop,
	output logic                                   kind,
	output logic signed [tsr_pkg::SAMPLE_BITS-1:0] out_value,
	output logic                                   dropped,
	input  logic                                   cfg_write,
	input  logic [tsr_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [tsr_pkg::CFG_DATA_W-1:0]         cfg_data
);
	import tsr_pkg::*;

	cfg_t        cfg_q;
	cmd_item_t   in_item;
	cmd_item_t   eng_cmd;
	logic        eng_cmd_valid;
	logic        eng_cmd_pop;
	res_item_t   eng_res;
	logic        eng_res_valid;
	logic        eng_res_ready;
	res_item_t   out_item;
	eng_status_t eng_status;

	// Configuration registers: a write is registered directly, no read-back.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.period <= PERIOD_BITS'(PERIOD_RESET);
			cfg_q.start  <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_PERIOD: cfg_q.period <= cfg_data[PERIOD_BITS-1:0];
				REG_START:  cfg_q.start  <= cfg_data[STAMP_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	// Only bit 0 of cmd matters; a tick ignores the stamp and value.
	assign in_item.cmd   = cmd_t'(cmd);
	assign in_item.stamp = stamp_us;
	assign in_item.value = in_value;

	// Front: hold accepted items until the engine pulls them.
	tsr_cmd_queue u_cmd_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (push),
		.wr_item  (in_item),
		.full     (full),
		.rd_valid (eng_cmd_valid),
		.rd_en    (eng_cmd_pop),
		.rd_item  (eng_cmd)
	);

	// Back: sample store, drain/peek sequencer, divider and interpolator.
	tsr_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.cmd_valid (eng_cmd_valid),
		.cmd_item  (eng_cmd),
		.cmd_pop   (eng_cmd_pop),
		.res_valid (eng_res_valid),
		.res_item  (eng_res),
		.res_ready (eng_res_ready),
		.status    (eng_status)
	);

	// Result side: decouple the engine from a stalling receiver.
	tsr_result_queue u_result_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (eng_res_valid),
		.wr_item  (eng_res),
		.wr_ready (eng_res_ready),
		.empty    (empty),
		.pop      (pop),
		.rd_item  (out_item)
	);

	assign kind      = out_item.kind;
	assign out_value = out_item.value;
	assign dropped   = out_item.dropped;

`ifndef SYNTHESIS
	// A dropped push is only reported while the store is full.
	assert property (@(posedge clk) disable iff (!arst_n)
		(eng_res_valid && eng_res.dropped) |-> (eng_status.fill == FILL_W'(FIFO_DEPTH)))
	else $error("dropped push reported with room in the sample store");

	// The store fill moves by at most one entry per cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (eng_status.fill == $past(eng_status.fill)
			|| eng_status.fill == $past(eng_status.fill) + FILL_W'(1)
			|| eng_status.fill == $past(eng_status.fill) - FILL_W'(1)))
	else $error("sample store fill jumped");

	// An idle engine picks up a waiting command at once.
	assert property (@(posedge clk) disable iff (!arst_n)
		(eng_status.idle && eng_cmd_valid) |=> !eng_status.idle)
	else $error("engine left a queued command waiting");
`endif

endmodule

// ----- dv/timestamped_sample_resampler_core_tb.sv -----
`timescale 1ns / 1ps

module timestamped_sample_resampler_core_tb;
	import tsr_pkg::*;

	localparam int          HALF_PERIOD  = 5;
	localparam int          RESET_CYCLES = 8;
	localparam int          DRAIN_CYCLES = 60;
	localparam int          RANDOM_ITEMS = 1650;
	localparam int          RANDOM_PHASES = 6;
	localparam int          TIMEOUT_NS   = 20_000_000;
	// Start the play clock just below the top of the stamp range so that it
	// can be walked onto the wrap point later.
	localparam stamp_t      START_HIGH   = 48'hFFFF_FFFF_F000;

	typedef enum int {
		RX_STREAM,
		RX_HALF,
		RX_SPARSE,
		RX_STRIDE
	} rx_mode_t;

	logic                  clk       = 1'b0;
	logic                  arst_n;
	logic                  push      = 1'b0;
	logic                  full;
	logic                  cmd       = 1'b0;
	stamp_t                stamp_us  = '0;
	sample_t               in_value  = '0;
	logic                  empty;
	logic                  pop       = 1'b0;
	logic                  kind;
	sample_t               out_value;
	logic                  dropped;
	logic                  cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = REG_PERIOD;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	always #(HALF_PERIOD) clk = ~clk;

	timestamped_sample_resampler_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.cmd       (cmd),
		.stamp_us  (stamp_us),
		.in_value  (in_value),
		.empty     (empty),
		.pop       (pop),
		.kind      (kind),
		.out_value (out_value),
		.dropped   (dropped),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Mirror of the resampler: sample store, the two bracketing samples,
	// the play clock and both registers.
	stamp_t    store_stamp[$];
	sample_t   store_level[$];
	stamp_t    prev_stamp_m = '0;
	sample_t   prev_level_m = '0;
	stamp_t    next_stamp_m = '0;
	sample_t   next_level_m = '0;
	stamp_t    play_us      = '0;
	logic      play_running = 1'b0;
	period_t   period_cfg   = period_t'(PERIOD_RESET);
	stamp_t    start_cfg    = '0;

	res_item_t pending_results[$];

	int        error_count = 0;
	int        n_checked   = 0;
	int        n_push      = 0;
	int        n_drop      = 0;
	int        n_tick      = 0;
	int        burst_left  = 0;
	int unsigned rx_cycle  = 0;
	rx_mode_t  rx_mode     = RX_STREAM;

	task automatic report_mismatch(string what, longint got, longint want);
		$display("MISMATCH %s at result %0d: got %0d expected %0d", what, n_checked, got, want);
		error_count++;
	endtask

	// Linear interpolation between the bracketing samples at the play clock.
	function automatic sample_t interp_output();
		stamp_t             span;
		stamp_t             play_dist;
		logic [63:0]        scaled;
		logic [16:0]        frac;
		logic signed [16:0] diff;
		logic signed [35:0] prod;
		// Hold the older level when the span is empty or backwards.
		if (next_stamp_m <= prev_stamp_m)
			return prev_level_m;
		span = next_stamp_m - prev_stamp_m;
		if (play_us <= prev_stamp_m) begin
			frac = '0;
		end else begin
			play_dist = play_us - prev_stamp_m;
			if (play_dist >= span) begin
				frac = 17'h10000;
			end else begin
				scaled = {play_dist, 16'h0000} / {16'h0000, span};
				frac   = scaled[16:0];
			end
		end
		diff = $signed({next_level_m[SAMPLE_BITS-1], next_level_m})
			- $signed({prev_level_m[SAMPLE_BITS-1], prev_level_m});
		prod = $signed({1'b0, frac}) * diff;
		// Arithmetic shift gives floor rounding for both signs.
		return prev_level_m + sample_t'(prod >>> FRAC_BITS);
	endfunction

	// Apply one accepted item to the mirror and queue the result it causes.
	task automatic predict_item(cmd_t c, stamp_t s, sample_t v);
		res_item_t r;
		r.kind    = KIND_PUSH;
		r.value   = '0;
		r.dropped = 1'b0;
		if (c == CMD_PUSH) begin
			n_push++;
			if (store_stamp.size() >= FIFO_DEPTH) begin
				r.dropped = 1'b1;
				n_drop++;
			end else begin
				store_stamp.push_back(s);
				store_level.push_back(v);
			end
		end else begin
			n_tick++;
			if (!play_running) begin
				play_us      = start_cfg;
				play_running = 1'b1;
			end
			// Drain everything due, then peek the first later sample.
			while (store_stamp.size() > 0 && store_stamp[0] <= play_us) begin
				prev_stamp_m = store_stamp.pop_front();
				prev_level_m = store_level.pop_front();
			end
			if (store_stamp.size() > 0) begin
				next_stamp_m = store_stamp[0];
				next_level_m = store_level[0];
			end
			r.kind  = KIND_SAMPLE;
			r.value = interp_output();
			play_us = play_us + stamp_t'(period_cfg);
		end
		pending_results.push_back(r);
	endtask

	// Transfer one item. Bursts of random length are separated by random
	// gaps; push stays high between items of a burst.
	task automatic send_item(cmd_t c, stamp_t s, sample_t v);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				push <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
				: $urandom_range(1, 16);
		end
		burst_left--;
		push     <= 1'b1;
		cmd      <= c;
		stamp_us <= s;
		in_value <= v;
		do @(posedge clk); while (full);
		predict_item(c, s, v);
	endtask

	// Stop sending and wait until every expected result has been popped.
	task automatic drain_results();
		push       <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	// Write the selected registers back to back; only call with the block idle.
	task automatic program_regs(logic wr_period, logic [CFG_DATA_W-1:0] period_word,
		logic wr_start, stamp_t start_word);
		if (wr_period) begin
			cfg_write <= 1'b1;
			cfg_index <= REG_PERIOD;
			cfg_data  <= period_word;
			@(posedge clk);
			period_cfg = period_word[PERIOD_BITS-1:0];
		end
		if (wr_start) begin
			cfg_write <= 1'b1;
			cfg_index <= REG_START;
			cfg_data  <= start_word;
			@(posedge clk);
			start_cfg = start_word;
		end
		cfg_write <= 1'b0;
	endtask

	// Result side: check each transfer against the oldest expectation, then
	// pick the pop level for the next cycle from the current stall mode.
	always @(posedge clk) begin : result_check
		res_item_t exp_r;
		if (arst_n && pop && !empty) begin
			if (pending_results.size() == 0) begin
				report_mismatch("result with nothing expected, kind", longint'(kind), -1);
			end else begin
				exp_r = pending_results.pop_front();
				if (kind !== exp_r.kind)
					report_mismatch("kind", longint'(kind), longint'(exp_r.kind));
				if (out_value !== exp_r.value)
					report_mismatch("out_value", longint'(out_value), longint'(exp_r.value));
				if (dropped !== exp_r.dropped)
					report_mismatch("dropped", longint'(dropped), longint'(exp_r.dropped));
				n_checked++;
			end
		end
		rx_cycle++;
		if (rx_cycle % 128 == 0)
			rx_mode = rx_mode_t'($urandom_range(0, 3));
		case (rx_mode)
			RX_STREAM: pop <= 1'b1;
			RX_HALF:   pop <= 1'($urandom_range(0, 1));
			RX_SPARSE: pop <= ($urandom_range(0, 7) == 0);
			default:   pop <= (rx_cycle % 5 == 0);
		endcase
	end

	// First tick loads the play clock from the start register; the period
	// stays at its reset value. Covers the empty store, equal stamps, an
	// out-of-order sample, a stale next sample and the clamp at full scale.
	task automatic test_first_tick();
		drain_results();
		program_regs(1'b0, '0, 1'b1, START_HIGH);
		send_item(CMD_TICK, '1, 16'sh7FFF);
		send_item(CMD_PUSH, START_HIGH + 30, 16'sh7FFF);
		send_item(CMD_PUSH, START_HIGH + 74, 16'sh8000);
		send_item(CMD_PUSH, START_HIGH + 74, 16'sd100);
		send_item(CMD_PUSH, START_HIGH + 40, -16'sd5);
		repeat (5) send_item(CMD_TICK, '0, '0);
	endtask

	// Step the play clock exactly onto the top stamp, then over the wrap.
	task automatic test_clock_wrap();
		stamp_t step;
		stamp_t base;
		drain_results();
		step = stamp_t'('1) - play_us;
		// Start write has no effect once the clock runs; write it anyway.
		program_regs(1'b1, CFG_DATA_W'(step[PERIOD_BITS-1:0]), 1'b1, '0);
		send_item(CMD_PUSH, '1, -16'sd1);
		send_item(CMD_PUSH, 48'd1500, 16'sd20000);
		send_item(CMD_PUSH, 48'd1000, 16'sd77);
		repeat (2) send_item(CMD_TICK, 48'h5555_5555_5555, 16'sh5555);
		base = play_us;
		send_item(CMD_PUSH, base + 38, 16'sd30000);
		send_item(CMD_PUSH, base + 5038, -16'sd30000);
		repeat (3) send_item(CMD_TICK, 48'hAAAA_AAAA_AAAA, 16'shAAAA);
	endtask

	// Period zero (with junk above the field) freezes the clock; then the
	// smallest and the largest period values.
	task automatic test_period_zero();
		stamp_t base;
		drain_results();
		program_regs(1'b1, {28'hA5A5A5A, 20'h00000}, 1'b1, stamp_t'({$urandom, $urandom}));
		base = play_us;
		send_item(CMD_PUSH, base, 16'sd1234);
		send_item(CMD_PUSH, base + 49, -16'sd1234);
		repeat (2) send_item(CMD_TICK, '0, '0);
		drain_results();
		program_regs(1'b1, CFG_DATA_W'(1), 1'b0, '0);
		repeat (2) send_item(CMD_TICK, '0, '0);
		drain_results();
		program_regs(1'b1, CFG_DATA_W'({PERIOD_BITS{1'b1}}), 1'b0, '0);
		repeat (2) send_item(CMD_TICK, '0, '0);
	endtask

	// Fill the store past its depth with future samples, then drain it all
	// in a single tick.
	task automatic test_store_overflow();
		stamp_t base;
		drain_results();
		program_regs(1'b1, CFG_DATA_W'(22), 1'b0, '0);
		base = play_us + 5000;
		for (int i = 0; i < FIFO_DEPTH + 3; i++)
			send_item(CMD_PUSH, base + stamp_t'(2 * i), sample_t'($urandom));
		send_item(CMD_TICK, stamp_t'({$urandom, $urandom}), sample_t'($urandom));
		send_item(CMD_PUSH, base + 10000, sample_t'($urandom));
		drain_results();
		program_regs(1'b1, CFG_DATA_W'(1_000_000), 1'b0, '0);
		repeat (3) send_item(CMD_TICK, stamp_t'({$urandom, $urandom}), sample_t'($urandom));
	endtask

	// Mostly a well-formed stream that keeps pace with the play clock, with
	// some late, duplicate and scattered samples mixed in, over several periods.
	task automatic test_random_stream();
		stamp_t      cursor;
		stamp_t      late_off;
		period_t     per;
		int unsigned span_max;
		int          pick;
		sample_t     lvl;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0:       per = period_t'($urandom_range(1, 40));
				1:       per = period_t'(1_000_000);
				2:       per = period_t'($urandom_range(1, 1_000_000));
				3:       per = period_t'(1);
				4:       per = '0;
				default: per = period_t'($urandom_range(20, 200));
			endcase
			drain_results();
			program_regs(1'b1, CFG_DATA_W'(per), 1'b1, stamp_t'({$urandom, $urandom}));
			cursor   = play_us;
			span_max = 2 * per + 1;
			for (int n = 0; n < RANDOM_ITEMS / RANDOM_PHASES; n++) begin
				pick = $urandom_range(0, 99);
				if ($urandom_range(0, 15) == 0)
					lvl = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
				else
					lvl = sample_t'($urandom);
				if (pick < 45) begin
					send_item(CMD_TICK, stamp_t'({$urandom, $urandom}), sample_t'($urandom));
				end else begin
					if (cursor < play_us)
						cursor = play_us;
					if (pick < 90) begin
						// Advance about one period per sample, sometimes not at all.
						cursor += stamp_t'($urandom_range(0, span_max));
						send_item(CMD_PUSH, cursor, lvl);
					end else if (pick < 95) begin
						// Late sample: already behind the play clock.
						late_off = stamp_t'($urandom_range(0, span_max));
						if (late_off > play_us)
							late_off = play_us;
						send_item(CMD_PUSH, play_us - late_off, lvl);
					end else begin
						send_item(CMD_PUSH, play_us + stamp_t'($urandom_range(0, 2 * span_max)),
							lvl);
					end
				end
			end
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		test_first_tick();
		test_clock_wrap();
		test_period_zero();
		test_store_overflow();
		test_random_stream();
		drain_results();
		// Hold a little longer to catch any stray result.
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Covered %0d pushes (%0d dropped) and %0d ticks, %0d results checked,",
			n_push, n_drop, n_tick, n_checked);
		$display("over the clock wrap, a full sample store and periods from zero to maximum.");
		if (error_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#(TIMEOUT_NS);
		$display("Timeout with %0d results still expected", pending_results.size());
		$display("Some tests failed");
		$finish;
	end

endmodule
